// File: hdl/mwr_pkg.sv
// Shared constants and types for the max-width-ramp block.
// No dependencies; imported by mwr_cell and max_width_ramp_core.
package mwr_pkg;

  localparam int MWR_MAX_LEN     = 256;
  localparam int MWR_SAMPLE_BITS = 16;
  localparam int MWR_IN_BITS     = 16;  // fixed width of the sample port
  localparam int MWR_WIDTH_BITS  = 8;   // fixed width of reported ramp widths

  // Control flags that ride along with an item through the cell chain.
  typedef struct packed {
    logic vld;     // stage holds an item
    logic first;   // item starts a new sequence
    logic ovf;     // item lies beyond the maximum length
    logic found;   // an earlier stack entry at or below the sample was hit
    logic pushed;  // sample has been written into a cell
  } mwr_ctl_t;

endpackage

// File: hdl/mwr_cell.sv
// One stack cell of the max-width-ramp chain: holds one prefix minimum and
// updates/forwards the item passing through it. Depends on mwr_pkg.
module mwr_cell import mwr_pkg::*; #(
  parameter int SAMPLE_BITS = MWR_SAMPLE_BITS,
  parameter int POS_BITS    = $clog2(MWR_MAX_LEN)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  mwr_ctl_t                  i_ctl,
  input  logic [SAMPLE_BITS-1:0]    i_smp,
  input  logic [POS_BITS-1:0]       i_pos,
  input  logic [MWR_WIDTH_BITS-1:0] i_here,
  output mwr_ctl_t                  o_ctl,
  output logic [SAMPLE_BITS-1:0]    o_smp,
  output logic [POS_BITS-1:0]       o_pos,
  output logic [MWR_WIDTH_BITS-1:0] o_here
);

  localparam int DIFF_BITS = (POS_BITS > MWR_WIDTH_BITS) ? POS_BITS : MWR_WIDTH_BITS;
  localparam logic [DIFF_BITS-1:0] WIDTH_SAT = DIFF_BITS'((1 << MWR_WIDTH_BITS) - 1);

  // stored stack entry
  logic                      occ_r, occ_nxt;
  logic [SAMPLE_BITS-1:0]    val_r;
  logic [POS_BITS-1:0]       cpos_r;

  // item stage register
  mwr_ctl_t                  ctl_r, ctl_nxt;
  logic [SAMPLE_BITS-1:0]    smp_r;
  logic [POS_BITS-1:0]       pos_r;
  logic [MWR_WIDTH_BITS-1:0] here_r, here_nxt;

  logic                      occ_eff;
  logic                      active;
  logic                      hit;
  logic                      push;
  logic [DIFF_BITS-1:0]      diff;

  always_comb begin
    // a first item clears the stack as it sweeps down the chain
    occ_eff = occ_r & ~i_ctl.first;
    active  = i_ctl.vld & ~i_ctl.ovf;
    // stack values fall toward the top, so the first hit is the earliest entry
    hit     = active & occ_eff & ~i_ctl.found & (val_r <= i_smp);
    // nothing at or below the sample: it is a new minimum, goes in first free cell
    push    = active & ~occ_eff & ~i_ctl.found & ~i_ctl.pushed;
    diff    = DIFF_BITS'(i_pos) - DIFF_BITS'(cpos_r);

    occ_nxt = active ? (occ_eff | push) : occ_r;

    ctl_nxt        = i_ctl;
    ctl_nxt.found  = i_ctl.found | hit;
    ctl_nxt.pushed = i_ctl.pushed | push;

    here_nxt = i_here;
    if (hit) begin
      here_nxt = (diff > WIDTH_SAT) ? WIDTH_SAT[MWR_WIDTH_BITS-1:0]
                                    : diff[MWR_WIDTH_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      ctl_r <= '0;
    end else if (adv) begin
      occ_r <= occ_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (push) begin
        val_r  <= i_smp;
        cpos_r <= i_pos;
      end
      smp_r  <= i_smp;
      pos_r  <= i_pos;
      here_r <= here_nxt;
    end
  end

  assign o_ctl  = ctl_r;
  assign o_smp  = smp_r;
  assign o_pos  = pos_r;
  assign o_here = here_r;

endmodule

// File: hdl/max_width_ramp_core.sv
// Max-width-ramp core: a chain of MAX_LEN stack cells plus position counter
// and running-best output stage. Depends on mwr_pkg and mwr_cell.
//
// Takes one sample per cycle and returns, for each, the widest ramp ending
// there and the widest ramp of the sequence so far. Each item walks the
// chain of MAX_LEN cells, one cell per cycle, behind the item before it;
// every cell holds one prefix minimum of the sequence. A new item may enter
// every cycle, so the sustained rate is one item per clock, and after the
// item is accepted its result passes through the MAX_LEN cell registers
// and then the output register. A stalled output holds the whole chain.
module max_width_ramp_core import mwr_pkg::*; #(
  parameter int MAX_LEN     = MWR_MAX_LEN,
  parameter int SAMPLE_BITS = MWR_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MWR_IN_BITS-1:0]    in_sample,
  input  logic                      in_first,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [MWR_WIDTH_BITS-1:0] out_best_width,
  output logic [MWR_WIDTH_BITS-1:0] out_width_here,
  output logic                      out_overflow
);

  localparam int POS_BITS = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_BITS = $clog2(MAX_LEN + 1);

  logic                      adv;
  logic [CNT_BITS-1:0]       np_r;
  logic [CNT_BITS-1:0]       base;
  logic                      in_ovf;
  logic [SAMPLE_BITS-1:0]    in_smp;

  mwr_ctl_t                  ch_ctl  [MAX_LEN+1];
  logic [SAMPLE_BITS-1:0]    ch_smp  [MAX_LEN+1];
  logic [POS_BITS-1:0]       ch_pos  [MAX_LEN+1];
  logic [MWR_WIDTH_BITS-1:0] ch_here [MAX_LEN+1];

  logic [MWR_WIDTH_BITS-1:0] best_r, best_nxt;
  logic                      out_valid_r;
  logic [MWR_WIDTH_BITS-1:0] out_best_r;
  logic [MWR_WIDTH_BITS-1:0] out_here_r;
  logic                      out_ovf_r;

  // whole chain moves when the output register is free or being emptied
  assign adv      = ~out_valid_r | out_ready;
  assign in_ready = adv;

  generate
    if (SAMPLE_BITS <= MWR_IN_BITS) begin : g_smp_narrow
      assign in_smp = in_sample[SAMPLE_BITS-1:0];
    end else begin : g_smp_wide
      assign in_smp = SAMPLE_BITS'(in_sample);
    end
  endgenerate

  // position counter
  always_comb begin
    base   = in_first ? '0 : np_r;
    in_ovf = (base == CNT_BITS'(MAX_LEN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_r <= '0;
    end else if (in_valid && adv) begin
      np_r <= in_ovf ? base : base + CNT_BITS'(1);
    end
  end

  always_comb begin
    ch_ctl[0]        = '0;
    ch_ctl[0].vld    = in_valid;
    ch_ctl[0].first  = in_first;
    ch_ctl[0].ovf    = in_ovf;
    ch_smp[0]        = in_smp;
    ch_pos[0]        = base[POS_BITS-1:0];
    ch_here[0]       = '0;
  end

  generate
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
      mwr_cell #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_BITS    (POS_BITS)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .i_ctl  (ch_ctl[k]),
        .i_smp  (ch_smp[k]),
        .i_pos  (ch_pos[k]),
        .i_here (ch_here[k]),
        .o_ctl  (ch_ctl[k+1]),
        .o_smp  (ch_smp[k+1]),
        .o_pos  (ch_pos[k+1]),
        .o_here (ch_here[k+1])
      );
    end
  endgenerate

  // running best, applied in item order at the end of the chain
  always_comb begin
    best_nxt = ch_ctl[MAX_LEN].first ? '0 : best_r;
    if (!ch_ctl[MAX_LEN].ovf && (ch_here[MAX_LEN] > best_nxt)) begin
      best_nxt = ch_here[MAX_LEN];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ch_ctl[MAX_LEN].vld;
      if (ch_ctl[MAX_LEN].vld) begin
        best_r <= best_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ch_ctl[MAX_LEN].vld) begin
      out_best_r <= best_nxt;
      out_here_r <= ch_ctl[MAX_LEN].ovf ? '0 : ch_here[MAX_LEN];
      out_ovf_r  <= ch_ctl[MAX_LEN].ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_width = out_best_r;
  assign out_width_here = out_here_r;
  assign out_overflow   = out_ovf_r;

`ifndef ASSERT_OFF
  a_ovf_no_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_width_here == '0)
    else $error("overflow item reports a nonzero ramp width");

  a_here_le_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_width_here <= out_best_width)
    else $error("ramp ending here exceeds best width");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    np_r <= CNT_BITS'(MAX_LEN))
    else $error("position counter beyond maximum length");
`endif

endmodule
